### src/ddo_pkg.sv
// shared types, constants and the cordic angle table for the odometry block
package ddo_pkg;

	localparam int unsigned AtanLen = 24;
	localparam logic [19:0] YawGainReset = 20'd31606;
	localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
	localparam logic signed [33:0] HalfQ30 = 34'sd536870912;

	typedef logic [31:0] atan_t [AtanLen];

	localparam atan_t AtanTurn = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic        start;
		logic [15:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic               done;
		logic signed [33:0] cos_v;
		logic signed [33:0] sin_v;
	} cordic_rsp_t;

	function automatic logic [31:0] atan_of(input logic [4:0] i);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < AtanLen; k++) begin
			if (i == 5'(k)) begin
				r = AtanTurn[k];
			end
		end
		return r;
	endfunction

	function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
		logic signed [34:0] t;
		logic signed [19:0] r;
		t = 35'(v) + 35'sd16384;
		r = 20'(t >>> 15);
		if (r > 20'sd32767) begin
			return 16'sh7fff;
		end
		if (r < -20'sd32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

endpackage

### src/ddo_cordic.sv
// iterative cordic: cosine and sine of a 16-bit binary angle in signed q4.30
module ddo_cordic #(
	parameter int unsigned Steps = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ddo_pkg::cordic_req_t req,
	output ddo_pkg::cordic_rsp_t rsp
);
	import ddo_pkg::*;

	localparam int unsigned NSteps = (Steps < AtanLen) ? Steps : AtanLen;

	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic               flip_q;
	logic               busy_q;
	logic               done_q;
	logic [4:0]         i_q;
	logic signed [15:0] a_fold;
	logic               a_flip;
	logic signed [33:0] xs, ys, at;

	always_comb begin
		a_fold = req.angle;
		a_flip = 1'b0;
		if ($signed(req.angle) > 16'sd16384) begin
			a_fold = req.angle - 16'h8000;
			a_flip = 1'b1;
		end else if ($signed(req.angle) < -16'sd16384) begin
			a_fold = req.angle + 16'h8000;
			a_flip = 1'b1;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = $signed({2'b00, atan_of(i_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == 5'(NSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= CordicGainQ30;
			y_q    <= '0;
			z_q    <= {{2{a_fold[15]}}, a_fold, 16'd0};
			flip_q <= a_flip;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = flip_q ? -x_q : x_q;
	assign rsp.sin_v = flip_q ? -y_q : y_q;
endmodule

### src/ddo_serdiv.sv
// restoring bit-serial divider: signed 64-bit numerator by 16-bit count, saturated to 32 bits
module ddo_serdiv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic [15:0]        den,
	output logic               done,
	output logic signed [31:0] quo
);
	logic [63:0] q_q;
	logic [16:0] r_q;
	logic [6:0]  n_q;
	logic        busy_q, done_q, neg_q, zero_q, nz_q;
	logic [15:0] d_q;
	logic [16:0] r_sh, r_sub;
	logic [63:0] mag;

	assign mag   = num[63] ? 64'(-num) : 64'(num);
	assign r_sh  = {r_q[15:0], q_q[63]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= '0;
			end else if (busy_q) begin
				n_q <= n_q + 7'd1;
				if (n_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= mag;
			r_q    <= '0;
			d_q    <= den;
			neg_q  <= num[63];
			zero_q <= (den == '0);
			nz_q   <= (num != '0);
		end else if (busy_q) begin
			if (!r_sub[16]) begin
				r_q <= r_sub;
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) begin
			quo = !nz_q ? 32'sd0 : (neg_q ? 32'sh80000000 : 32'sh7fffffff);
		end else if (neg_q) begin
			quo = (q_q > 64'h80000000) ? 32'sh80000000 : 32'(-q_q);
		end else begin
			quo = (q_q > 64'h7fffffff) ? 32'sh7fffffff : q_q[31:0];
		end
	end
	assign done = done_q;
endmodule

### src/differential_drive_odometry.sv
// differential drive odometry top level
// channel | dir | contents
// s_axis  | in  | left_distance, right_distance, elapsed_ms
// m_axis  | out | pos_x, pos_y, heading, quat_z, quat_w, linear_speed, angular_speed
// cfg     | in  | yaw_gain
// one beat at a time: the next input beat is taken only after the result has been accepted
// the time to the result is set by the first
// cordic pass and then the 64-step serial dividers, which start with the second cordic pass
// reset clears state, gain returns to 31606. a stalled result blocks the next beat.
module differential_drive_odometry #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // left_distance, right_distance, elapsed_ms
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [175:0] m_axis_tdata,  // pos_x, pos_y, heading, quat_z, quat_w, lin, ang
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [19:0]  cfg_data
);
	import ddo_pkg::*;

	typedef enum logic [2:0] {
		IDLE, PREP, ROT1, MUL, ROT2, WAITD, OUT
	} state_t;

	state_t state_q;
	logic [19:0] gain_q;
	logic [31:0] prev_l_q, prev_r_q, px_q, py_q;
	logic [15:0] yaw_q, ms_q;
	logic signed [32:0] dl_q, dr_q;
	logic signed [32:0] dist_q;
	logic signed [53:0] dyaw_q;
	logic signed [15:0] qz_q, qw_q;
	logic signed [31:0] lin_q, ang_q;
	logic lin_ok_q, ang_ok_q;
	logic signed [66:0] px_m_q, py_m_q;

	cordic_req_t creq;
	cordic_rsp_t crsp;
	logic div_go;
	logic lin_done, ang_done;
	logic signed [31:0] lin_quo, ang_quo;
	logic signed [53:0] dyaw_c;
	logic signed [15:0] mid, nyaw;

	ddo_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp)
	);
	ddo_serdiv u_lin (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(64'(dist_q) * 64'sd1000), .den(ms_q), .done(lin_done), .quo(lin_quo)
	);
	ddo_serdiv u_ang (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(64'(dyaw_q) * 64'sd1000), .den(ms_q), .done(ang_done), .quo(ang_quo)
	);

	assign dyaw_c = 54'(((dr_q - dl_q) * $signed({1'b0, gain_q}) + 54'sd32768) >>> 16);
	assign mid    = yaw_q + 16'(dyaw_c >>> 1);
	assign nyaw   = yaw_q + dyaw_q[15:0];
	assign div_go = (state_q == MUL);

	always_comb begin
		creq.start = 1'b0;
		creq.angle = mid;
		if (state_q == PREP) begin
			creq.start = 1'b1;
		end else if (state_q == MUL) begin
			creq.start = 1'b1;
			creq.angle = 16'($signed(yaw_q) >>> 1);
		end
	end

	assign s_axis_tready = (state_q == IDLE);
	assign cfg_ready     = (state_q == IDLE);
	assign m_axis_tvalid = (state_q == OUT);
	assign m_axis_tdata  = {ang_q, lin_q, qw_q, qz_q, yaw_q, py_q, px_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			gain_q   <= YawGainReset;
			prev_l_q <= '0;
			prev_r_q <= '0;
			px_q     <= '0;
			py_q     <= '0;
			yaw_q    <= '0;
			lin_ok_q <= 1'b0;
			ang_ok_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (cfg_valid) begin
						gain_q <= cfg_data;
					end
					if (s_axis_tvalid) begin
						state_q  <= PREP;
						prev_l_q <= s_axis_tdata[31:0];
						prev_r_q <= s_axis_tdata[63:32];
					end
				end
				PREP: state_q <= ROT1;
				ROT1: begin
					if (crsp.done) begin
						state_q <= MUL;
						yaw_q   <= nyaw;
					end
				end
				MUL: begin
					state_q  <= ROT2;
					lin_ok_q <= 1'b0;
					ang_ok_q <= 1'b0;
					px_q     <= px_q + 32'((px_m_q + 67'(HalfQ30)) >>> 30);
					py_q     <= py_q + 32'((py_m_q + 67'(HalfQ30)) >>> 30);
				end
				ROT2: begin
					if (lin_done) lin_ok_q <= 1'b1;
					if (ang_done) ang_ok_q <= 1'b1;
					if (crsp.done) state_q <= WAITD;
				end
				WAITD: begin
					if (lin_done) lin_ok_q <= 1'b1;
					if (ang_done) ang_ok_q <= 1'b1;
					if ((lin_ok_q || lin_done) && (ang_ok_q || ang_done)) begin
						state_q <= OUT;
					end
				end
				OUT: begin
					if (m_axis_tready) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && s_axis_tvalid) begin
			dl_q <= 33'($signed(s_axis_tdata[31:0] - prev_l_q));
			dr_q <= 33'($signed(s_axis_tdata[63:32] - prev_r_q));
			ms_q <= s_axis_tdata[79:64];
		end
		if (state_q == PREP) begin
			dist_q <= (dl_q + dr_q) >>> 1;
			dyaw_q <= dyaw_c;
		end
		if (state_q == ROT1 && crsp.done) begin
			px_m_q <= 67'(dist_q) * 67'(crsp.cos_v);
			py_m_q <= 67'(dist_q) * 67'(crsp.sin_v);
		end
		if (crsp.done && state_q == ROT2) begin
			qz_q <= to_q15(crsp.sin_v);
			qw_q <= to_q15(crsp.cos_v);
		end
		if (lin_done) lin_q <= lin_quo;
		if (ang_done) ang_q <= ang_quo;
	end

`ifndef ASSERT_OFF
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != IDLE |-> !s_axis_tready)
		else $error("input ready while busy");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != IDLE |=> $stable(gain_q) || $past(state_q) == IDLE)
		else $error("gain changed while busy");
`endif
endmodule

### tb/sv/differential_drive_odometry_tb.sv
// testbench for differential drive odometry: scoreboard prediction, directed and random traffic
`timescale 1ns / 1ps

module differential_drive_odometry_tb;
	import ddo_pkg::*;

	localparam int Steps = 16;
	localparam int Latency = 2 * Steps + 80;

	typedef struct packed {
		logic signed [31:0] ang;
		logic signed [31:0] lin;
		logic signed [15:0] qw;
		logic signed [15:0] qz;
		logic signed [15:0] hd;
		logic signed [31:0] py;
		logic signed [31:0] px;
	} odo_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [175:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [19:0] cfg_data = '0;

	int errors = 0;
	int src_idle = 6;
	int snk_idle = 58;
	bit hold_sink = 1'b0;
	int beats_in = 0;
	int beats_out = 0;

	always #4 clk = ~clk;

	differential_drive_odometry #(.CORDIC_STEPS(Steps)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s at result %0d: got %0d want %0d", what, beats_out, got, want);
		errors++;
	endtask

	function automatic longint asr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic int wrap16(input longint v);
		logic signed [15:0] t;
		t = v[15:0];
		return int'(t);
	endfunction

	function automatic longint q15(input longint v);
		longint r;
		r = asr(v + 16384, 15);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	function automatic longint rate(input longint num, input longint den);
		longint r;
		if (den == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
		r = num / den;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r;
	endfunction

	task automatic rotate(input int angle, output longint c, output longint s);
		longint x, y, z, nx;
		bit flip;
		flip = 1'b0;
		x = 652032874;
		y = 0;
		if (angle > 16384) begin
			angle -= 32768;
			flip = 1'b1;
		end else if (angle < -16384) begin
			angle += 32768;
			flip = 1'b1;
		end
		z = longint'(angle) * 65536;
		for (int i = 0; i < Steps && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - asr(y, i);
				y = y + asr(x, i);
				z -= longint'(AtanTurn[i]);
			end else begin
				nx = x + asr(y, i);
				y = y - asr(x, i);
				z += longint'(AtanTurn[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	class odo_scoreboard;
		logic [19:0] gain;
		logic [31:0] last_l, last_r, pos_x, pos_y;
		logic [15:0] yaw;
		odo_out_t pending[$];

		function new();
			gain = YawGainReset;
			last_l = 0; last_r = 0; pos_x = 0; pos_y = 0; yaw = 0;
		endfunction

		task note_input(input logic [79:0] d);
			longint dl, dr, mean_d, dyaw, c, s, qc, qs;
			int y0, mid, ny;
			logic [31:0] l, r, t;
			odo_out_t o;
			l = d[31:0];
			r = d[63:32];
			t = l - last_l; dl = longint'(signed'(t));
			t = r - last_r; dr = longint'(signed'(t));
			last_l = l; last_r = r;
			mean_d = asr(dl + dr, 1);
			dyaw = asr((dr - dl) * longint'(gain) + 32768, 16);
			y0 = wrap16(longint'(signed'(yaw)));
			mid = wrap16(longint'(y0) + asr(dyaw, 1));
			rotate(mid, c, s);
			t = 32'(asr(mean_d * c + 536870912, 30)); pos_x += t;
			t = 32'(asr(mean_d * s + 536870912, 30)); pos_y += t;
			ny = wrap16(longint'(y0) + dyaw);
			yaw = ny[15:0];
			rotate(ny >>> 1, qc, qs);
			o.px = pos_x; o.py = pos_y; o.hd = yaw;
			o.qz = 16'(q15(qs)); o.qw = 16'(q15(qc));
			o.lin = 32'(rate(mean_d * 1000, longint'(d[79:64])));
			o.ang = 32'(rate(dyaw * 1000, longint'(d[79:64])));
			pending.push_back(o);
		endtask

		task check_result(input logic [175:0] d);
			odo_out_t g, w;
			g = d;
			if (pending.size() == 0) begin
				report("unexpected beat", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (g.px !== w.px) report("pos_x", g.px, w.px);
			if (g.py !== w.py) report("pos_y", g.py, w.py);
			if (g.hd !== w.hd) report("heading", g.hd, w.hd);
			if (g.qz !== w.qz) report("quat_z", g.qz, w.qz);
			if (g.qw !== w.qw) report("quat_w", g.qw, w.qw);
			if (g.lin !== w.lin) report("linear_speed", g.lin, w.lin);
			if (g.ang !== w.ang) report("angular_speed", g.ang, w.ang);
		endtask
	endclass

	odo_scoreboard sb = new();

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sb.note_input(s_axis_tdata);
			beats_in++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
			beats_out++;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle);
	end

	task automatic send(input logic [31:0] l, input logic [31:0] r, input logic [15:0] ms);
		while ($urandom_range(99) < src_idle) @(negedge clk);
		s_axis_tdata = {ms, r, l};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (Latency) @(negedge clk);
	endtask

	task automatic write_gain(input logic [19:0] g);
		drain();
		cfg_data <= g;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.gain = g;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom();
	endfunction

	task automatic random_run(input int n);
		logic [31:0] l, r, step;
		logic [15:0] ms;
		l = sb.last_l;
		r = sb.last_r;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin
					l = rnd32(); r = rnd32();
				end
				1, 2: begin
					step = $urandom_range(400000);
					l += step - 200000;
					r += step - 200000 + $urandom_range(20000) - 10000;
				end
				default: begin
					l += $urandom_range(40000) - 20000;
					r += $urandom_range(40000) - 20000;
				end
			endcase
			case ($urandom_range(9))
				0: ms = $urandom_range(65535);
				1: ms = 16'd1;
				default: ms = $urandom_range(100, 1);
			endcase
			send(l, r, ms);
		end
	endtask

	initial begin
		#5ms;
		$display("timeout after %0d inputs and %0d results", beats_in, beats_out);
		$display("differential_drive_odometry_tb: FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		send(32'h0000_0000, 32'h0000_0000, 16'd20);
		send(32'h0001_0000, 32'h0001_0000, 16'd20);
		send(32'h0000_0000, 32'h0002_0000, 16'd40);
		send(32'h7fff_ffff, 32'h8000_0000, 16'd1);
		send(32'h8000_0000, 32'h7fff_ffff, 16'd65535);
		send(32'hffff_ffff, 32'hffff_ffff, 16'd0);
		send(32'hffff_ffff, 32'hffff_ffff, 16'd0);
		send(32'h0000_0000, 32'h7fff_ffff, 16'd0);
		send(32'h1234_5678, 32'hedcb_a987, 16'hffff);
		send(32'h0000_8000, 32'h0000_0000, 16'd33);
		write_gain(20'd0);
		send(32'h0100_0000, 32'h0000_0000, 16'd10);
		send(32'hff00_0000, 32'h0300_0000, 16'd0);
		write_gain(20'hfffff);
		send(32'h0000_0000, 32'h0000_4000, 16'd5);
		send(32'h8000_0000, 32'h7fff_ffff, 16'd1);
		send(32'h0000_0000, 32'h0000_0000, 16'd1);
		write_gain(20'd1);
		send(32'h7fff_ffff, 32'h8000_0000, 16'd3);
		write_gain(YawGainReset);

		random_run(300);
		hold_sink = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_sink = 1'b0;
			end
			random_run(5);
		join
		hold_sink = 1'b0;
		drain();
		src_idle = 58;
		snk_idle = 6;
		write_gain(20'd200000);
		random_run(300);
		write_gain(20'd1);
		random_run(100);
		src_idle = 0;
		snk_idle = 0;
		write_gain(20'hfffff);
		random_run(100);
		write_gain(20'd0);
		random_run(100);
		write_gain(YawGainReset);
		random_run(200);
		drain();

		$display("covered %0d input beats and %0d result beats over five gain settings",
			beats_in, beats_out);
		$display("included wraparound, zero elapsed time, zero and full gain, sink backpressure");
		if (errors == 0 && sb.pending.size() == 0) begin
			$display("differential_drive_odometry_tb: PASS");
		end else begin
			$display("differential_drive_odometry_tb: FAIL");
		end
		$finish;
	end

endmodule

### sim.f
src/ddo_pkg.sv
src/ddo_cordic.sv
src/ddo_serdiv.sv
src/differential_drive_odometry.sv
tb/sv/differential_drive_odometry_tb.sv
